[rtl/clipped_alpha_blend_blit_assert.svh]
// Assertion macros for the blend blitter; each use sits on a line of its own.
`ifndef CLIPPED_ALPHA_BLEND_BLIT_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_BLIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CABB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CABB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cabb_pkg.sv]
package cabb_pkg;

  localparam int unsigned MaxDimension = 4096;
  localparam int unsigned DimW   = 13;
  localparam int unsigned CntW   = 12;
  localparam int unsigned OffW   = 12;
  localparam int unsigned AddrW  = 24;
  localparam int unsigned TotalW = 25;
  localparam int unsigned ChanW  = 8;

  localparam logic [DimW-1:0]   DimMax   = DimW'(MaxDimension);
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [2:0] {
    CfgSourceWidth  = 3'd0,
    CfgSourceHeight = 3'd1,
    CfgDestWidth    = 3'd2,
    CfgDestHeight   = 3'd3,
    CfgOffsetX      = 3'd4,
    CfgOffsetY      = 3'd5
  } cfg_idx_e;

  // One item after placement and clipping, before blend and address math.
  typedef struct packed {
    chan_t             src_red;
    chan_t             src_green;
    chan_t             src_blue;
    chan_t             src_alpha;
    chan_t             dst_red;
    chan_t             dst_green;
    chan_t             dst_blue;
    logic              in_dest;
    logic              wr_en;
    logic              last;
    logic [DimW-1:0]   dx;
    logic [DimW-1:0]   dy;
    logic [DimW-1:0]   dw;
    logic [TotalW-1:0] count;
  } place_t;

endpackage

[rtl/cabb_mix.sv]
module cabb_mix
  import cabb_pkg::*;
(
  input  chan_t dst_i,
  input  chan_t src_i,
  input  chan_t alpha_i,
  output chan_t mix_o
);

  logic signed [ChanW:0]       diff;
  logic signed [2*ChanW+1:0]   prod;
  logic        [2*ChanW-1:0]   base;
  logic signed [2*ChanW+1:0]   total;
  logic        [2*ChanW-1:0]   x;
  logic        [2*ChanW:0]     q_sum;

  // dst*(255-a) + src*a == dst*255 + (src-dst)*a, one multiply per channel.
  assign diff  = $signed({1'b0, src_i}) - $signed({1'b0, dst_i});
  assign prod  = diff * $signed({1'b0, alpha_i});
  assign base  = {dst_i, {ChanW{1'b0}}} - {{ChanW{1'b0}}, dst_i};
  assign total = $signed({2'b00, base}) + prod;
  assign x     = total[2*ChanW-1:0];

  // Exact floor(x/255) for x up to 255*255.
  assign q_sum = {1'b0, x} + {{(ChanW+1){1'b0}}, x[2*ChanW-1:ChanW]} + (2*ChanW+1)'(1);
  assign mix_o = q_sum[2*ChanW-1:ChanW];

endmodule

[rtl/clipped_alpha_blend_blit.sv]
// Items pass through the placement register, then the result register, from input accept to result valid.
// Throughput: one item per cycle while results are taken; the pixel and result stages advance together as a pipeline.
// Stall: s_axis_tready_o drops only when both stages are full and the result is not taken.
// Reset (rst_ni low, asynchronous): pipeline empties, counters and pixel count clear,
// sizes return to 1x1 source and destination with zero offset.
module clipped_alpha_blend_blit
  import cabb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i,
  // input items
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue (8 bits each)
  input  logic [55:0]  s_axis_tdata_i,
  // result items
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // dest_address[23:0], out_red, out_green, out_blue, blended_count[24:0], zero pad
  output logic [79:0]  m_axis_tdata_o,
  // write_enable
  output logic         m_axis_tuser_o,
  // frame_last
  output logic         m_axis_tlast_o
);

  `include "clipped_alpha_blend_blit_assert.svh"

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [DimW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [OffW-1:0] off_x_q, off_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DimW'(1);
      src_h_q <= DimW'(1);
      dst_w_q <= DimW'(1);
      dst_h_q <= DimW'(1);
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgSourceWidth:  src_w_q <= cfg_data_i;
        CfgSourceHeight: src_h_q <= cfg_data_i;
        CfgDestWidth:    dst_w_q <= cfg_data_i;
        CfgDestHeight:   dst_h_q <= cfg_data_i;
        CfgOffsetX:      off_x_q <= cfg_data_i[OffW-1:0];
        CfgOffsetY:      off_y_q <= cfg_data_i[OffW-1:0];
        default: ;       // drop writes beyond the register list
      endcase
    end
  end

  // Effective sizes: source dims at least 1, all dims saturate at the maximum.
  // A zero destination dim stays zero so nothing lands inside.
  logic [DimW-1:0] sw_eff, sh_eff, dw_eff, dh_eff;

  always_comb begin
    sw_eff = (src_w_q == '0) ? DimW'(1) : ((src_w_q > DimMax) ? DimMax : src_w_q);
    sh_eff = (src_h_q == '0) ? DimW'(1) : ((src_h_q > DimMax) ? DimMax : src_h_q);
    dw_eff = (dst_w_q > DimMax) ? DimMax : dst_w_q;
    dh_eff = (dst_h_q > DimMax) ? DimMax : dst_h_q;
  end

  // ---------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------
  logic   s1_valid_q, out_valid_q;
  logic   out_load, s1_load, s_fire;
  place_t s1_q, s1_d;

  // The result register loads from a full placement register whenever it is empty or being drained; the
  // placement register loads whenever its content moves on or it is empty.
  assign out_load        = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_load         = s_fire;

  // ---------------------------------------------------------------
  // Placement, clipping and frame counters (at accept)
  // ---------------------------------------------------------------
  logic [CntW-1:0]   col_q, row_q, col_d, row_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [DimW-1:0]   dx, dy, col_nx, row_nx;
  logic              in_dest, wr_en, row_end, last;

  always_comb begin
    dx      = {1'b0, col_q} + {1'b0, off_x_q};
    dy      = {1'b0, row_q} + {1'b0, off_y_q};
    in_dest = (dx < dw_eff) && (dy < dh_eff);
    wr_en   = in_dest && (s_axis_tdata_i[31:24] != '0);
    col_nx  = {1'b0, col_q} + DimW'(1);
    row_nx  = {1'b0, row_q} + DimW'(1);
    // A counter already at or past a shrunken size ends its row or frame now.
    row_end = col_nx >= sw_eff;
    last    = row_end && (row_nx >= sh_eff);

    total_d = total_q;
    if (wr_en && (total_q != TotalMax)) begin
      total_d = total_q + TotalW'(1);
    end

    s1_d.src_red   = s_axis_tdata_i[7:0];
    s1_d.src_green = s_axis_tdata_i[15:8];
    s1_d.src_blue  = s_axis_tdata_i[23:16];
    s1_d.src_alpha = s_axis_tdata_i[31:24];
    s1_d.dst_red   = s_axis_tdata_i[39:32];
    s1_d.dst_green = s_axis_tdata_i[47:40];
    s1_d.dst_blue  = s_axis_tdata_i[55:48];
    s1_d.in_dest   = in_dest;
    s1_d.wr_en     = wr_en;
    s1_d.last      = last;
    s1_d.dx        = dx;
    s1_d.dy        = dy;
    s1_d.dw        = dw_eff;
    s1_d.count     = total_d;

    priority if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_nx[CntW-1:0];
    end else begin
      col_d = col_nx[CntW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      total_q <= '0;
    end else if (s_fire) begin
      col_q   <= col_d;
      row_q   <= row_d;
      // Clear the pixel count at frame end; the item itself carries the total.
      total_q <= last ? '0 : total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load || out_load) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------
  // Blend and address (placement register -> result register)
  // ---------------------------------------------------------------
  chan_t            mix_r, mix_g, mix_b;
  logic [2*DimW-1:0] row_base;
  logic [AddrW-1:0]  addr_d;

  cabb_mix u_mix_r (
    .dst_i   (s1_q.dst_red),
    .src_i   (s1_q.src_red),
    .alpha_i (s1_q.src_alpha),
    .mix_o   (mix_r)
  );

  cabb_mix u_mix_g (
    .dst_i   (s1_q.dst_green),
    .src_i   (s1_q.src_green),
    .alpha_i (s1_q.src_alpha),
    .mix_o   (mix_g)
  );

  cabb_mix u_mix_b (
    .dst_i   (s1_q.dst_blue),
    .src_i   (s1_q.src_blue),
    .alpha_i (s1_q.src_alpha),
    .mix_o   (mix_b)
  );

  // Address wraps to 24 bits; clipped pixels report address zero.
  assign row_base = s1_q.dy * s1_q.dw;
  assign addr_d   = s1_q.in_dest ? (row_base[AddrW-1:0] + AddrW'(s1_q.dx)) : '0;

  logic [AddrW-1:0]  addr_q;
  chan_t             red_q, green_q, blue_q;
  logic [TotalW-1:0] count_q;
  logic              wr_en_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load || m_axis_tready_i) begin
      out_valid_q <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      addr_q  <= addr_d;
      red_q   <= mix_r;
      green_q <= mix_g;
      blue_q  <= mix_b;
      count_q <= s1_q.count;
      wr_en_q <= s1_q.wr_en;
      last_q  <= s1_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, count_q, blue_q, green_q, red_q, addr_q};
  assign m_axis_tuser_o  = wr_en_q;
  assign m_axis_tlast_o  = last_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `CABB_ASSERT_NOW(a_we_has_count, m_axis_tvalid_o && m_axis_tuser_o, count_q != '0, "written item with zero count")
  `CABB_ASSERT_NEXT(a_frame_clear, s_fire && last, (col_q == '0) && (row_q == '0) && (total_q == '0), "counters not cleared at frame end")
  `CABB_ASSERT_NOW(a_stall_full, !s_axis_tready_o, s1_valid_q && out_valid_q, "input stalled with a free stage")
  `CABB_ASSERT_NOW(a_we_in_dest, s1_valid_q && s1_q.wr_en, s1_q.in_dest, "write enable on a clipped pixel")

endmodule

[test/clipped_alpha_blend_blit_checker.sv]
module clipped_alpha_blend_blit_checker
  import cabb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [DimW-1:0]   cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue (8 bits each)
  input  logic [55:0]       s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  // dest_address[23:0], out_red, out_green, out_blue, blended_count[24:0], zero pad
  input  logic [79:0]       m_tdata_i,
  // write_enable
  input  logic              m_tuser_i,
  // frame_last
  input  logic              m_tlast_i,
  output int unsigned       pending_o,
  output int unsigned       mismatches_o
);

  localparam int unsigned ChanFull = 255;

  // Lowest field first in the bus, so it sits last in the packed struct.
  typedef struct packed {
    chan_t dst_blue;
    chan_t dst_green;
    chan_t dst_red;
    chan_t src_alpha;
    chan_t src_blue;
    chan_t src_green;
    chan_t src_red;
  } pixel_t;

  typedef struct packed {
    logic              wr_en;
    logic [AddrW-1:0]  addr;
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    logic [TotalW-1:0] count;
    logic              last;
  } pixel_write_t;

  logic [DimW-1:0]   src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [OffW-1:0]   off_x_q, off_y_q;
  logic [CntW-1:0]   col_q, row_q;
  logic [TotalW-1:0] blended_q;
  pixel_write_t      predicted_writes_q[$];
  int unsigned       result_idx;
  int unsigned       mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  function automatic int unsigned clamp_size(input logic [DimW-1:0] v,
                                             input int unsigned lowest);
    if (v < lowest) return lowest;
    if (v > MaxDimension) return MaxDimension;
    return 32'(v);
  endfunction

  function automatic chan_t mix_channel(input chan_t dst, input chan_t src,
                                        input int unsigned alpha);
    int unsigned sum;
    sum = dst * (ChanFull - alpha) + src * alpha;
    return chan_t'(sum / ChanFull);
  endfunction

  // Place, clip and blend one source pixel, then advance the raster position.
  function automatic pixel_write_t blit_pixel(input pixel_t pix);
    pixel_write_t res;
    int unsigned  sw, sh, dw, dh, dx, dy, alpha;
    logic         in_dest, row_end;
    sw     = clamp_size(src_w_q, 1);
    sh     = clamp_size(src_h_q, 1);
    dw     = clamp_size(dst_w_q, 0);
    dh     = clamp_size(dst_h_q, 0);
    alpha  = pix.src_alpha;
    dx     = col_q + off_x_q;
    dy     = row_q + off_y_q;
    in_dest = (dx < dw) && (dy < dh);
    res.wr_en = in_dest && (alpha != 0);
    res.addr  = in_dest ? AddrW'(dx + dy * dw) : '0;
    res.red   = mix_channel(pix.dst_red, pix.src_red, alpha);
    res.green = mix_channel(pix.dst_green, pix.src_green, alpha);
    res.blue  = mix_channel(pix.dst_blue, pix.src_blue, alpha);
    if (res.wr_en && blended_q != TotalMax) blended_q++;
    res.count = blended_q;
    row_end   = (col_q + 32'd1) >= sw;
    res.last  = row_end && ((row_q + 32'd1) >= sh);
    if (res.last) begin
      col_q     = '0;
      row_q     = '0;
      blended_q = '0;
    end else if (row_end) begin
      col_q = '0;
      row_q++;
    end else begin
      col_q++;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: result %0d %s got 0x%0h expected 0x%0h", result_idx, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_write();
    pixel_write_t want;
    if (predicted_writes_q.size() == 0) begin
      report_mismatch("unrequested result, address", m_tdata_i[23:0], 0);
    end else begin
      want = predicted_writes_q.pop_front();
      if (m_tuser_i !== want.wr_en) report_mismatch("write_enable", m_tuser_i, want.wr_en);
      if (m_tdata_i[23:0] !== want.addr) report_mismatch("dest_address", m_tdata_i[23:0], want.addr);
      if (m_tdata_i[31:24] !== want.red) report_mismatch("out_red", m_tdata_i[31:24], want.red);
      if (m_tdata_i[39:32] !== want.green) report_mismatch("out_green", m_tdata_i[39:32], want.green);
      if (m_tdata_i[47:40] !== want.blue) report_mismatch("out_blue", m_tdata_i[47:40], want.blue);
      if (m_tdata_i[72:48] !== want.count) begin
        report_mismatch("blended_count", m_tdata_i[72:48], want.count);
      end
      if (m_tdata_i[79:73] !== '0) report_mismatch("pad", m_tdata_i[79:73], 0);
      if (m_tlast_i !== want.last) report_mismatch("frame_last", m_tlast_i, want.last);
    end
    result_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    = 1;
      src_h_q    = 1;
      dst_w_q    = 1;
      dst_h_q    = 1;
      off_x_q    = '0;
      off_y_q    = '0;
      col_q      = '0;
      row_q      = '0;
      blended_q  = '0;
      result_idx = 0;
      predicted_writes_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSourceWidth:  src_w_q = cfg_data_i;
          CfgSourceHeight: src_h_q = cfg_data_i;
          CfgDestWidth:    dst_w_q = cfg_data_i;
          CfgDestHeight:   dst_h_q = cfg_data_i;
          CfgOffsetX:      off_x_q = cfg_data_i[OffW-1:0];
          CfgOffsetY:      off_y_q = cfg_data_i[OffW-1:0];
          default: ;  // indexes past the register list are dropped
        endcase
      end
      // Check before predicting so a result cannot match an item taken at the same edge.
      if (m_tvalid_i && m_tready_i) check_write();
      if (s_tvalid_i && s_tready_i) predicted_writes_q.push_back(blit_pixel(pixel_t'(s_tdata_i)));
      pending_o <= predicted_writes_q.size();
    end
  end

endmodule

[test/tb_clipped_alpha_blend_blit.sv]
module tb_clipped_alpha_blend_blit;
  import cabb_pkg::*;

  // Stop the random part after roughly this many pixels.
  localparam int unsigned RandomItems = 1950;
  // Longest idle stretch either side draws per item.
  localparam int unsigned MaxGap      = 18;
  // Settle time after the last result; comfortably above the two-stage pipeline.
  localparam int unsigned DrainCycles = 8;
  // Register indexes past the end of the list; writes there must be dropped.
  localparam logic [2:0]  CfgReservedLo = 3'd6;
  localparam logic [2:0]  CfgReservedHi = 3'd7;

  typedef struct {
    logic [DimW-1:0] src_w;
    logic [DimW-1:0] src_h;
    logic [DimW-1:0] dst_w;
    logic [DimW-1:0] dst_h;
    logic [DimW-1:0] off_x;
    logic [DimW-1:0] off_y;
  } blit_setting_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_index_i;
  logic [DimW-1:0]   cfg_data_i;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue (8 bits each)
  logic [55:0]       s_axis_tdata_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  // dest_address[23:0], out_red, out_green, out_blue, blended_count[24:0], zero pad
  logic [79:0]       m_axis_tdata_o;
  // write_enable
  logic              m_axis_tuser_o;
  // frame_last
  logic              m_axis_tlast_o;

  int unsigned       writes_pending;
  int unsigned       mismatches;

  // Per-phase switches: when set, that side never idles.
  bit                src_burst;
  bit                sink_burst;

  clipped_alpha_blend_blit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Watch both channels and the register port; predict and compare every result.
  clipped_alpha_blend_blit_checker blit_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .m_tlast_i    (m_axis_tlast_o),
    .pending_o    (writes_pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("[clipped_alpha_blend_blit] ERROR");
    $finish;
  end

  // Pack one item, first field in the lowest byte.
  function automatic logic [55:0] pack_pixel(input chan_t sr, input chan_t sg, input chan_t sb,
                                             input chan_t a, input chan_t dr, input chan_t dg,
                                             input chan_t db);
    return {db, dg, dr, a, sb, sg, sr};
  endfunction

  // Favor fully transparent and fully opaque pixels; they take the special paths.
  function automatic logic [55:0] random_pixel();
    chan_t alpha;
    case ($urandom_range(0, 7))
      0:       alpha = 8'h00;
      1:       alpha = 8'hFF;
      default: alpha = chan_t'($urandom);
    endcase
    return pack_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), alpha,
                      chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
  endfunction

  // Mostly small sizes so frames wrap often; now and then a zero, a boundary or
  // an oversized value that must saturate.
  function automatic logic [DimW-1:0] pick_size(input int unsigned span);
    if ($urandom_range(0, 7) != 0) return DimW'($urandom_range(0, span));
    case ($urandom_range(0, 4))
      0:       return 13'd4095;
      1:       return 13'd4096;
      2:       return 13'd4097;
      3:       return 13'd8191;
      default: return 13'd0;
    endcase
  endfunction

  // Offsets are 12 bits; values with bit 12 set check that the top bit is dropped.
  function automatic logic [DimW-1:0] pick_offset();
    if ($urandom_range(0, 7) != 0) return DimW'($urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0:       return 13'd4095;
      1:       return 13'd4096;
      2:       return 13'd8191;
      default: return DimW'($urandom);
    endcase
  endfunction

  function automatic blit_setting_t pick_setting();
    blit_setting_t s;
    s.src_w = pick_size(8);
    s.src_h = pick_size(6);
    s.dst_w = pick_size(10);
    s.dst_h = pick_size(8);
    s.off_x = pick_offset();
    s.off_y = pick_offset();
    return s;
  endfunction

  // Hold the write for one edge.
  task automatic write_reg(input logic [2:0] idx, input logic [DimW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  // Drop valid and hold until the checker has seen every predicted write, then settle.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (writes_pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Reprogram only with the pipeline empty; also poke one unused index.
  task automatic apply_setting(input blit_setting_t cfg);
    wait_drained();
    write_reg(CfgSourceWidth, cfg.src_w);
    write_reg(CfgSourceHeight, cfg.src_h);
    write_reg(CfgDestWidth, cfg.dst_w);
    write_reg(CfgDestHeight, cfg.dst_h);
    write_reg(CfgOffsetX, cfg.off_x);
    write_reg(CfgOffsetY, cfg.off_y);
    write_reg($urandom_range(0, 1) ? CfgReservedLo : CfgReservedHi, DimW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Idle for a random gap, then present the item and hold it until taken.
  task automatic send_pixel(input logic [55:0] pix);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= pix;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Result side: stall a random number of cycles before each result, keep ready
  // high through back-to-back results when the draw is zero.
  initial begin : result_sink
    int unsigned hold;
    m_axis_tready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = sink_burst ? 0 : $urandom_range(0, MaxGap);
      if (hold != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  initial begin : stimulus
    blit_setting_t setting;
    int unsigned   sent;
    int unsigned   phase_items;
    int unsigned   pause_at;
    int unsigned   k;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: 1x1 source on a 1x1 destination, so every pixel is a whole frame
    // at address zero. Walk the channel and alpha extremes.
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Transparent: no write, colors pass the destination through.
    send_pixel(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'h3C));
    // Opaque: colors take the source.
    send_pixel(pack_pixel(8'h12, 8'h34, 8'h56, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00));
    send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pack_pixel(8'hFF, 8'h00, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h7F));
    send_pixel(pack_pixel(8'h80, 8'h7F, 8'h01, 8'h7F, 8'h7F, 8'h80, 8'hFE));

    // 3x2 source shifted one column right onto a 2x1 destination: clip on the
    // right edge and on the second row.
    setting = '{13'd3, 13'd2, 13'd2, 13'd1, 13'd1, 13'd0};
    apply_setting(setting);
    repeat (6) send_pixel(random_pixel());

    // Zero destination: nothing lies inside.
    setting = '{13'd2, 13'd1, 13'd0, 13'd0, 13'd0, 13'd0};
    apply_setting(setting);
    repeat (2) send_pixel(random_pixel());

    // Oversized destination saturates to the maximum; the first source pixel lands on the
    // top address, the rest of the 2x2 source falls outside.
    setting = '{13'd2, 13'd2, 13'd8191, 13'd8191, 13'd8191, 13'd4095};
    apply_setting(setting);
    repeat (4) send_pixel(random_pixel());

    // Random phases: fresh registers each time, frames left unfinished across
    // phases so shrinking sizes end rows and frames early.
    sent = 0;
    while (sent < RandomItems) begin
      setting = pick_setting();
      apply_setting(setting);
      src_burst   = ($urandom_range(0, 3) == 0);
      sink_burst  = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(20, 160);
      // About half the phases also drain once mid-stream.
      pause_at    = $urandom_range(1, 2 * phase_items);
      for (k = 0; k < phase_items; k++) begin
        if (k == pause_at) wait_drained();
        send_pixel(random_pixel());
      end
      sent += phase_items;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[clipped_alpha_blend_blit] OK");
    end else begin
      $display("[clipped_alpha_blend_blit] ERROR");
    end
    $finish;
  end

endmodule

[clipped_alpha_blend_blit.f]
+incdir+rtl
rtl/cabb_pkg.sv
rtl/cabb_mix.sv
rtl/clipped_alpha_blend_blit.sv
test/clipped_alpha_blend_blit_checker.sv
test/tb_clipped_alpha_blend_blit.sv
